### rtl/psch_pkg.sv
// Shared types, constants and helper functions of the priority round-robin scheduler.
package psch_pkg;

    localparam int LEVELS      = 5;
    localparam int MAX_TASKS   = 64;
    localparam int QUEUE_DEPTH = 64;

    localparam int TASK_ID_W  = 6;
    localparam int PRIO_W     = 3;
    localparam int BURST_W    = 16;
    localparam int QUANTUM_W  = 8;
    localparam int SWITCH_W   = 32;
    localparam int KIND_W     = 2;

    localparam int LVL_IDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TASK_IDX_W = $clog2(MAX_TASKS);
    localparam int QPOS_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W    = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int QMEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int TMEM_W     = BURST_W + PRIO_W;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(2);

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [KIND_W-1:0] EV_ARR_OK    = 2'd0;
    localparam logic [KIND_W-1:0] EV_ARR_REJ   = 2'd1;
    localparam logic [KIND_W-1:0] EV_TICK_RAN  = 2'd2;
    localparam logic [KIND_W-1:0] EV_TICK_IDLE = 2'd3;

    typedef struct packed {
        logic                 opcode;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    priority_req;
        logic [BURST_W-1:0]   burst;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]    event_kind;
        logic [TASK_ID_W-1:0] ran_task;
        logic                 preempted;
        logic                 first_dispatch;
        logic                 finished;
        logic                 quantum_expired;
        logic                 context_switch;
        logic [SWITCH_W-1:0]  switch_count;
    } out_item_t;

    typedef struct packed {
        logic                 push;
        logic [LVL_IDX_W-1:0] push_lv;
        logic                 pop;
        logic [LVL_IDX_W-1:0] pop_lv;
    } lvl_cmd_t;

    typedef struct packed {
        logic                 any;
        logic [LVL_IDX_W-1:0] top;
        logic [LEVELS-1:0]    full;
    } lvl_status_t;

    // Zero-based level of a stored priority, clamped into range.
    function automatic logic [LVL_IDX_W-1:0] level_index(input logic [PRIO_W-1:0] lvl);
        logic [PRIO_W:0] c;
        c = {1'b0, lvl};
        if (c < (PRIO_W+1)'(1))
        begin
            c = (PRIO_W+1)'(1);
        end
        if (c > (PRIO_W+1)'(LEVELS))
        begin
            c = (PRIO_W+1)'(LEVELS);
        end
        return LVL_IDX_W'(c - (PRIO_W+1)'(1));
    endfunction

    function automatic logic [QADDR_W-1:0] queue_addr(input logic [LVL_IDX_W-1:0] lv,
                                                      input logic [QPOS_W-1:0] pos);
        return QADDR_W'(lv) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(pos);
    endfunction

endpackage

### rtl/psch_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module psch_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/psch_levels.sv
// Head, tail and fill bookkeeping of the per-level circular queues.
module psch_levels (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psch_pkg::lvl_cmd_t           cmd,
    output psch_pkg::lvl_status_t        stat,
    output logic [psch_pkg::QADDR_W-1:0] push_addr,
    output logic [psch_pkg::QADDR_W-1:0] pop_addr
);

    logic [psch_pkg::QPOS_W-1:0] head_reg  [psch_pkg::LEVELS];
    logic [psch_pkg::QPOS_W-1:0] tail_reg  [psch_pkg::LEVELS];
    logic [psch_pkg::QCNT_W-1:0] count_reg [psch_pkg::LEVELS];

    function automatic logic [psch_pkg::QPOS_W-1:0] next_pos(
        input logic [psch_pkg::QPOS_W-1:0] pos);
        if (pos == psch_pkg::QPOS_W'(psch_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return pos + psch_pkg::QPOS_W'(1);
    endfunction

    always_comb
    begin
        stat.any  = 1'b0;
        stat.top  = '0;
        stat.full = '0;
        for (int i = psch_pkg::LEVELS - 1; i >= 0; i--)
        begin
            stat.full[i] = (count_reg[i] == psch_pkg::QCNT_W'(psch_pkg::QUEUE_DEPTH));
            if (count_reg[i] != '0)
            begin
                stat.any = 1'b1;
                stat.top = psch_pkg::LVL_IDX_W'(i);
            end
        end
    end

    assign push_addr = psch_pkg::queue_addr(cmd.push_lv, tail_reg[cmd.push_lv]);
    assign pop_addr  = psch_pkg::queue_addr(stat.top, head_reg[stat.top]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psch_pkg::LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < psch_pkg::LEVELS; i++)
            begin
                logic do_push;
                logic do_pop;
                do_push = cmd.push && (cmd.push_lv == psch_pkg::LVL_IDX_W'(i));
                do_pop  = cmd.pop && (cmd.pop_lv == psch_pkg::LVL_IDX_W'(i));
                if (do_push)
                begin
                    tail_reg[i] <= next_pos(tail_reg[i]);
                end
                if (do_pop)
                begin
                    head_reg[i] <= next_pos(head_reg[i]);
                end
                if (do_push && !do_pop)
                begin
                    count_reg[i] <= count_reg[i] + psch_pkg::QCNT_W'(1);
                end
                else if (do_pop && !do_push)
                begin
                    count_reg[i] <= count_reg[i] - psch_pkg::QCNT_W'(1);
                end
            end
        end
    end

endmodule

### rtl/priority_round_robin_scheduler_core.sv
// Top level of the preemptive priority round-robin scheduler with its sequencer.
// From acceptance to a valid result an idle tick passes the emit step only, an arrival the
// arrival and emit steps, a tick of a running task the run and emit steps; a preempting arrival
// adds a requeue step, a dispatching tick a pop step. The next transaction is taken as the result
// appears; the registered memory reads are chained with their write-back, and output stalls hold emit.
// An asynchronous active-low reset clears levels, flags and counters and sets the quantum to 2.
module priority_round_robin_scheduler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  psch_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output psch_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [psch_pkg::QUANTUM_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARR,
        ST_ARR2,
        ST_TPOP,
        ST_TRUN,
        ST_EMIT
    } state_t;

    state_t                           state_reg;
    psch_pkg::in_item_t               item_reg;
    psch_pkg::out_item_t              res_reg;
    psch_pkg::out_item_t              out_reg;
    logic                             out_valid_reg;
    logic [psch_pkg::QUANTUM_W-1:0]   quantum_reg;
    logic [psch_pkg::TASK_ID_W-1:0]   running_task_reg;
    logic                             running_valid_reg;
    logic [psch_pkg::QUANTUM_W-1:0]   quantum_left_reg;
    logic [psch_pkg::TASK_ID_W-1:0]   last_disp_reg;
    logic                             last_valid_reg;
    logic [psch_pkg::SWITCH_W-1:0]    switch_total_reg;
    logic [psch_pkg::MAX_TASKS-1:0]   started_reg;
    logic [psch_pkg::LVL_IDX_W-1:0]   pop_lv_reg;
    logic [psch_pkg::LVL_IDX_W-1:0]   run_lv_reg;
    logic                             first_reg;
    logic                             cs_reg;

    psch_pkg::lvl_cmd_t               lvl_cmd;
    psch_pkg::lvl_status_t            lvl_stat;
    logic [psch_pkg::QADDR_W-1:0]     push_addr;
    logic [psch_pkg::QADDR_W-1:0]     pop_addr;

    logic                             qmem_we;
    logic [psch_pkg::TASK_ID_W-1:0]   qmem_wdata;
    logic                             qmem_re;
    logic [psch_pkg::TASK_ID_W-1:0]   qmem_rdata;

    logic                             tmem_we;
    logic [psch_pkg::TASK_IDX_W-1:0]  tmem_waddr;
    logic [psch_pkg::TMEM_W-1:0]      tmem_wdata;
    logic                             tmem_re;
    logic [psch_pkg::TASK_IDX_W-1:0]  tmem_raddr;
    logic [psch_pkg::TMEM_W-1:0]      tmem_rdata;

    logic                             accept;
    logic                             out_free;
    logic                             prio_ok;
    logic [psch_pkg::LVL_IDX_W-1:0]   arr_lv;
    logic                             arr_ok;
    logic [psch_pkg::LVL_IDX_W-1:0]   run_lv;
    logic                             preempt;
    logic [psch_pkg::BURST_W-1:0]     rem;
    logic [psch_pkg::PRIO_W-1:0]      rem_lvl;
    logic [psch_pkg::QUANTUM_W-1:0]   qdec;
    logic                             done;
    logic [psch_pkg::LVL_IDX_W-1:0]   req_lv;
    logic                             expire;
    logic                             requeue;
    logic [psch_pkg::TASK_ID_W-1:0]   pop_task;
    logic                             pop_first;
    logic                             pop_cs;
    psch_pkg::out_item_t              res_init;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        prio_ok = (item_reg.priority_req != '0) &&
                  ({1'b0, item_reg.priority_req} <= (psch_pkg::PRIO_W+1)'(psch_pkg::LEVELS));
        arr_lv  = psch_pkg::LVL_IDX_W'(item_reg.priority_req - psch_pkg::PRIO_W'(1));
        arr_ok  = prio_ok && (item_reg.burst != '0) &&
                  (int'(item_reg.task_id) < psch_pkg::MAX_TASKS) && !lvl_stat.full[arr_lv];
        run_lv  = psch_pkg::level_index(tmem_rdata[psch_pkg::PRIO_W-1:0]);
        preempt = running_valid_reg && (arr_lv < run_lv) && !lvl_stat.full[run_lv];

        rem     = tmem_rdata[psch_pkg::TMEM_W-1:psch_pkg::PRIO_W];
        rem_lvl = tmem_rdata[psch_pkg::PRIO_W-1:0];
        qdec    = quantum_left_reg - psch_pkg::QUANTUM_W'(1);
        done    = (rem <= psch_pkg::BURST_W'(1));
        req_lv  = psch_pkg::level_index(rem_lvl);
        expire  = !done && (qdec == '0);
        requeue = expire && !lvl_stat.full[req_lv];

        pop_task  = qmem_rdata;
        pop_first = !started_reg[psch_pkg::TASK_IDX_W'(pop_task)];
        pop_cs    = last_valid_reg && (last_disp_reg != pop_task);

        res_init              = '0;
        res_init.switch_count = switch_total_reg;
        if ((in_data.opcode == psch_pkg::OP_TICK) && !running_valid_reg && !lvl_stat.any)
        begin
            res_init.event_kind = psch_pkg::EV_TICK_IDLE;
        end
    end

    always_comb
    begin
        lvl_cmd.push    = 1'b0;
        lvl_cmd.push_lv = arr_lv;
        lvl_cmd.pop     = (state_reg == ST_TPOP);
        lvl_cmd.pop_lv  = pop_lv_reg;
        qmem_we         = 1'b0;
        qmem_wdata      = running_task_reg;
        qmem_re         = 1'b0;
        tmem_we         = 1'b0;
        tmem_waddr      = psch_pkg::TASK_IDX_W'(running_task_reg);
        tmem_wdata      = {(done ? psch_pkg::BURST_W'(0) : rem - psch_pkg::BURST_W'(1)), rem_lvl};
        tmem_re         = 1'b0;
        tmem_raddr      = psch_pkg::TASK_IDX_W'(running_task_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tmem_re = (in_data.opcode == psch_pkg::OP_ARRIVAL) || running_valid_reg;
                    qmem_re = (in_data.opcode == psch_pkg::OP_TICK) && !running_valid_reg &&
                              lvl_stat.any;
                end
            end
            ST_ARR:
            begin
                if (arr_ok)
                begin
                    lvl_cmd.push = 1'b1;
                    qmem_we      = 1'b1;
                    qmem_wdata   = item_reg.task_id;
                    tmem_we      = 1'b1;
                    tmem_waddr   = psch_pkg::TASK_IDX_W'(item_reg.task_id);
                    tmem_wdata   = {item_reg.burst, item_reg.priority_req};
                end
            end
            ST_ARR2:
            begin
                lvl_cmd.push    = 1'b1;
                lvl_cmd.push_lv = run_lv_reg;
                qmem_we         = 1'b1;
            end
            ST_TPOP:
            begin
                tmem_re    = 1'b1;
                tmem_raddr = psch_pkg::TASK_IDX_W'(pop_task);
            end
            ST_TRUN:
            begin
                tmem_we         = 1'b1;
                lvl_cmd.push    = requeue;
                lvl_cmd.push_lv = req_lv;
                qmem_we         = requeue;
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    psch_levels u_levels (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (lvl_cmd),
        .stat      (lvl_stat),
        .push_addr (push_addr),
        .pop_addr  (pop_addr)
    );

    psch_ram #(
        .WIDTH (psch_pkg::TASK_ID_W),
        .DEPTH (psch_pkg::QMEM_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (qmem_we),
        .waddr (push_addr),
        .wdata (qmem_wdata),
        .re    (qmem_re),
        .raddr (pop_addr),
        .rdata (qmem_rdata)
    );

    psch_ram #(
        .WIDTH (psch_pkg::TMEM_W),
        .DEPTH (psch_pkg::MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (tmem_we),
        .waddr (tmem_waddr),
        .wdata (tmem_wdata),
        .re    (tmem_re),
        .raddr (tmem_raddr),
        .rdata (tmem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            item_reg          <= '0;
            res_reg           <= '0;
            out_reg           <= '0;
            out_valid_reg     <= 1'b0;
            quantum_reg       <= psch_pkg::QUANTUM_RESET;
            running_task_reg  <= '0;
            running_valid_reg <= 1'b0;
            quantum_left_reg  <= '0;
            last_disp_reg     <= '0;
            last_valid_reg    <= 1'b0;
            switch_total_reg  <= '0;
            started_reg       <= '0;
            pop_lv_reg        <= '0;
            run_lv_reg        <= '0;
            first_reg         <= 1'b0;
            cs_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg   <= in_data;
                        res_reg    <= res_init;
                        first_reg  <= 1'b0;
                        cs_reg     <= 1'b0;
                        pop_lv_reg <= lvl_stat.top;
                        if (in_data.opcode == psch_pkg::OP_ARRIVAL)
                        begin
                            state_reg <= ST_ARR;
                        end
                        else if (running_valid_reg)
                        begin
                            state_reg <= ST_TRUN;
                        end
                        else if (lvl_stat.any)
                        begin
                            state_reg <= ST_TPOP;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_ARR:
                begin
                    state_reg <= ST_EMIT;
                    if (!arr_ok)
                    begin
                        res_reg.event_kind <= psch_pkg::EV_ARR_REJ;
                    end
                    else
                    begin
                        res_reg.event_kind <= psch_pkg::EV_ARR_OK;
                        started_reg[psch_pkg::TASK_IDX_W'(item_reg.task_id)] <= 1'b0;
                        if (preempt)
                        begin
                            res_reg.preempted <= 1'b1;
                            res_reg.ran_task  <= running_task_reg;
                            running_valid_reg <= 1'b0;
                            run_lv_reg        <= run_lv;
                            state_reg         <= ST_ARR2;
                        end
                    end
                end
                ST_ARR2:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_TPOP:
                begin
                    running_task_reg  <= pop_task;
                    running_valid_reg <= 1'b1;
                    quantum_left_reg  <= quantum_reg;
                    first_reg         <= pop_first;
                    cs_reg            <= pop_cs;
                    started_reg[psch_pkg::TASK_IDX_W'(pop_task)] <= 1'b1;
                    if (pop_cs)
                    begin
                        switch_total_reg <= switch_total_reg + psch_pkg::SWITCH_W'(1);
                    end
                    last_disp_reg  <= pop_task;
                    last_valid_reg <= 1'b1;
                    state_reg      <= ST_TRUN;
                end
                ST_TRUN:
                begin
                    res_reg.event_kind      <= psch_pkg::EV_TICK_RAN;
                    res_reg.ran_task        <= running_task_reg;
                    res_reg.first_dispatch  <= first_reg;
                    res_reg.context_switch  <= cs_reg;
                    res_reg.finished        <= done;
                    res_reg.quantum_expired <= requeue;
                    res_reg.switch_count    <= switch_total_reg;
                    if (done || requeue)
                    begin
                        running_valid_reg <= 1'b0;
                    end
                    if (expire && !requeue)
                    begin
                        quantum_left_reg <= quantum_reg;
                    end
                    else
                    begin
                        quantum_left_reg <= qdec;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_task_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(tmem_we && tmem_re))
        else $error("task memory read and written in the same cycle");

    a_queue_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(qmem_we && qmem_re))
        else $error("queue memory read and written in the same cycle");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        qmem_we |-> !lvl_stat.full[lvl_cmd.push_lv])
        else $error("push onto a full level");

    a_dispatch_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(running_valid_reg) |-> $past(state_reg == ST_TPOP))
        else $error("running task set outside of dispatch");

    a_result_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result loaded outside of the emit step");

endmodule

### test/priority_round_robin_scheduler_core_checker.sv
`timescale 1ns / 100ps
// Checker of the priority round-robin scheduler core: predicts each result and compares it.
module priority_round_robin_scheduler_core_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  psch_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  psch_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [psch_pkg::QUANTUM_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             pending
);
    import psch_pkg::*;

    logic [TASK_ID_W-1:0] lvq_store [LEVELS][QUEUE_DEPTH];
    logic [QPOS_W-1:0]    lvq_head  [LEVELS];
    logic [QPOS_W-1:0]    lvq_tail  [LEVELS];
    logic [QCNT_W-1:0]    lvq_count [LEVELS];

    logic [BURST_W-1:0]   burst_left    [MAX_TASKS];
    logic [PRIO_W-1:0]    task_prio     [MAX_TASKS];
    logic                 task_ran_once [MAX_TASKS];

    logic [TASK_ID_W-1:0] cur_task;
    logic                 cur_valid;
    logic [QUANTUM_W-1:0] slice_left;
    logic [TASK_ID_W-1:0] prev_task;
    logic                 prev_valid;
    logic [SWITCH_W-1:0]  switches;
    logic [QUANTUM_W-1:0] slice_len;

    out_item_t expected_events [$];

    task automatic reset_model();
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            lvq_head[lv]  = '0;
            lvq_tail[lv]  = '0;
            lvq_count[lv] = '0;
            for (int p = 0; p < QUEUE_DEPTH; p++)
            begin
                lvq_store[lv][p] = '0;
            end
        end
        for (int t = 0; t < MAX_TASKS; t++)
        begin
            burst_left[t]    = '0;
            task_prio[t]     = '0;
            task_ran_once[t] = 1'b0;
        end
        cur_task   = '0;
        cur_valid  = 1'b0;
        slice_left = '0;
        prev_task  = '0;
        prev_valid = 1'b0;
        switches   = '0;
        slice_len  = QUANTUM_W'(2);
        expected_events.delete();
    endtask

    function automatic bit level_is_full(input int lv);
        return lvq_count[lv] >= QCNT_W'(QUEUE_DEPTH);
    endfunction

    function automatic void enqueue_task(input int lv, input logic [TASK_ID_W-1:0] id);
        lvq_store[lv][lvq_tail[lv]] = id;
        lvq_tail[lv]  = (int'(lvq_tail[lv]) == QUEUE_DEPTH - 1) ? '0 : lvq_tail[lv] + 1'b1;
        lvq_count[lv] = lvq_count[lv] + 1'b1;
    endfunction

    function automatic logic [TASK_ID_W-1:0] dequeue_task(input int lv);
        logic [TASK_ID_W-1:0] id;
        id = lvq_store[lv][lvq_head[lv]];
        lvq_head[lv]  = (int'(lvq_head[lv]) == QUEUE_DEPTH - 1) ? '0 : lvq_head[lv] + 1'b1;
        lvq_count[lv] = lvq_count[lv] - 1'b1;
        return id;
    endfunction

    function automatic int task_level_idx(input logic [TASK_ID_W-1:0] id);
        int p;
        p = int'(task_prio[id]);
        if (p < 1)
            p = 1;
        if (p > LEVELS)
            p = LEVELS;
        return p - 1;
    endfunction

    function automatic out_item_t predict_schedule_event(input in_item_t item);
        out_item_t            r;
        int                   prio;
        int                   run_lv;
        int                   lv;
        bit                   bad;
        bit                   found;
        logic [TASK_ID_W-1:0] t;
        r    = '0;
        prio = int'(item.priority_req);
        if (item.opcode == OP_ARRIVAL)
        begin
            bad = (item.burst == '0) || (prio < 1) || (prio > LEVELS) ||
                  (int'(item.task_id) >= MAX_TASKS);
            if (!bad)
                bad = level_is_full(prio - 1);
            if (bad)
            begin
                r.event_kind = EV_ARR_REJ;
            end
            else
            begin
                r.event_kind = EV_ARR_OK;
                // The running task's level is taken before the arrival may overwrite it.
                run_lv = cur_valid ? task_level_idx(cur_task) : 0;
                burst_left[item.task_id]    = item.burst;
                task_prio[item.task_id]     = item.priority_req;
                task_ran_once[item.task_id] = 1'b0;
                enqueue_task(prio - 1, item.task_id);
                if (cur_valid && (prio - 1 < run_lv) && !level_is_full(run_lv))
                begin
                    enqueue_task(run_lv, cur_task);
                    cur_valid   = 1'b0;
                    r.preempted = 1'b1;
                    r.ran_task  = cur_task;
                end
            end
        end
        else
        begin
            if (!cur_valid)
            begin
                found = 1'b0;
                for (lv = 0; lv < LEVELS && !found; lv++)
                begin
                    if (lvq_count[lv] != '0)
                    begin
                        found      = 1'b1;
                        t          = dequeue_task(lv);
                        cur_task   = t;
                        cur_valid  = 1'b1;
                        slice_left = slice_len;
                        if (!task_ran_once[t])
                        begin
                            task_ran_once[t] = 1'b1;
                            r.first_dispatch = 1'b1;
                        end
                        if (prev_valid && prev_task != t)
                        begin
                            switches         = switches + 1'b1;
                            r.context_switch = 1'b1;
                        end
                        prev_task  = t;
                        prev_valid = 1'b1;
                    end
                end
            end
            if (!cur_valid)
            begin
                r.event_kind = EV_TICK_IDLE;
            end
            else
            begin
                t            = cur_task;
                r.event_kind = EV_TICK_RAN;
                r.ran_task   = t;
                slice_left   = slice_left - 1'b1;
                if (burst_left[t] <= BURST_W'(1))
                begin
                    burst_left[t] = '0;
                    r.finished    = 1'b1;
                    cur_valid     = 1'b0;
                end
                else
                begin
                    burst_left[t] = burst_left[t] - 1'b1;
                    if (slice_left == '0)
                    begin
                        lv = task_level_idx(t);
                        if (!level_is_full(lv))
                        begin
                            enqueue_task(lv, t);
                            cur_valid         = 1'b0;
                            r.quantum_expired = 1'b1;
                        end
                        else
                        begin
                            slice_left = slice_len;
                        end
                    end
                end
            end
        end
        r.switch_count = switches;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] check failed: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            reset_model();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("result with no transaction pending: kind %0d task %0d",
                                              out_data.event_kind, out_data.ran_task));
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", out_data.event_kind, want.event_kind);
                    check_field("ran_task", out_data.ran_task, want.ran_task);
                    check_field("preempted", out_data.preempted, want.preempted);
                    check_field("first_dispatch", out_data.first_dispatch, want.first_dispatch);
                    check_field("finished", out_data.finished, want.finished);
                    check_field("quantum_expired", out_data.quantum_expired,
                                want.quantum_expired);
                    check_field("context_switch", out_data.context_switch, want.context_switch);
                    check_field("switch_count", out_data.switch_count, want.switch_count);
                end
            end
            if (cfg_we)
                slice_len = cfg_wdata;
            if (in_valid && in_ready)
                expected_events.push_back(predict_schedule_event(in_data));
            pending <= expected_events.size();
        end
    end

endmodule

### test/priority_round_robin_scheduler_core_test.sv
`timescale 1ns / 100ps
// Testbench top of the priority round-robin scheduler core: stimulus, idling and verdict.
module priority_round_robin_scheduler_core_test;
    import psch_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1120;
    localparam int PHASES         = 6;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [QUANTUM_W-1:0] cfg_wdata = '0;

    int mismatches;
    int pending;
    int send_idle_pct = 25;
    int recv_idle_pct = 80;
    int idle_cycles   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    priority_round_robin_scheduler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    priority_round_robin_scheduler_core_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("priority_round_robin_scheduler_core: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_arrival(input int id, input int prio, input int burst);
        in_item_t item;
        item.opcode       = OP_ARRIVAL;
        item.task_id      = TASK_ID_W'(id);
        item.priority_req = PRIO_W'(prio);
        item.burst        = BURST_W'(burst);
        send_item(item);
    endtask

    task automatic send_ticks(input int count);
        in_item_t item;
        repeat (count)
        begin
            item.opcode       = OP_TICK;
            item.task_id      = TASK_ID_W'($urandom);
            item.priority_req = PRIO_W'($urandom);
            item.burst        = BURST_W'($urandom);
            send_item(item);
        end
    endtask

    task automatic wait_for_drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
        wait_for_drain(8);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic in_item_t random_item(input int tick_pct);
        in_item_t item;
        int       r;
        item.task_id      = TASK_ID_W'($urandom_range(MAX_TASKS - 1));
        item.priority_req = PRIO_W'($urandom_range(7));
        item.burst        = BURST_W'($urandom_range(65535));
        r = $urandom_range(99);
        if (r < tick_pct)
        begin
            item.opcode = OP_TICK;
        end
        else
        begin
            item.opcode = OP_ARRIVAL;
            if (r >= 95)
            begin
                // Broken arrivals: a level out of range or an empty burst.
                if ($urandom_range(1) == 0)
                    item.priority_req = ($urandom_range(2) == 0) ? '0 :
                                        PRIO_W'($urandom_range(7, LEVELS + 1));
                else
                    item.burst = '0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 2)
                begin
                    // Long jobs only go to the lowest level so that they cannot starve the rest.
                    item.priority_req = PRIO_W'(LEVELS);
                end
                else
                begin
                    item.priority_req = PRIO_W'($urandom_range(LEVELS, 1));
                    item.burst = (r < 87) ? BURST_W'($urandom_range(3, 1)) :
                                            BURST_W'($urandom_range(12, 4));
                end
            end
        end
        return item;
    endfunction

    initial
    begin
        int                   tick_pct;
        logic [QUANTUM_W-1:0] q;

        tick_pct = 70;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        send_ticks(1);
        send_arrival(5, 0, 3);
        send_arrival(5, 6, 3);
        send_arrival(5, 7, 3);
        send_arrival(5, 3, 0);
        send_arrival(63, LEVELS, 3);
        send_ticks(1);
        send_arrival(0, 1, 1);
        send_ticks(3);
        send_arrival(10, 2, 5);
        send_ticks(3);
        send_arrival(10, 4, 2);
        send_ticks(3);
        send_arrival(42, LEVELS, 65535);
        send_ticks(1);
        send_arrival(21, 1, 2);
        send_arrival(42, LEVELS, 1);
        send_ticks(40);

        // Fill the lowest level so that rejection, blocked preemption and blocked requeue occur.
        repeat (QUEUE_DEPTH)
            send_arrival($urandom_range(31), LEVELS, $urandom_range(6, 3));
        send_ticks(1);
        send_arrival(63, LEVELS, 4);
        send_arrival(62, LEVELS, 4);
        send_arrival(48, 1, 2);
        send_ticks(3);
        send_ticks(QUEUE_DEPTH * 7);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: q = QUANTUM_W'(1);
                1: q = QUANTUM_W'(255);
                2: q = QUANTUM_W'(0);
                3: q = QUANTUM_W'(4);
                4: q = QUANTUM_W'($urandom_range(12, 2));
                default: q = QUANTUM_W'(1);
            endcase
            write_quantum(q);
            send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 80 : 0;
            recv_idle_pct = (phase < 2) ? 80 : (phase < 4) ? 25 : 0;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (n % 50 == 0)
                    tick_pct = 50 + 20 * $urandom_range(2);
                send_item(random_item(tick_pct));
            end
        end

        wait_for_drain(10);
        if (mismatches == 0)
            $display("priority_round_robin_scheduler_core: match");
        else
            $display("priority_round_robin_scheduler_core: mismatch");
        $finish;
    end

endmodule
